// ----- hdl/tdfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Table-driven DFA acceptor package
// Field widths, item mode and error codes, configuration register indexes
// and the layout of one entry of the transition table.
// ----------------------------------------------------------------------------
package tdfa_pkg;

  // Widths of the channel fields and configuration registers.
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned SYMBOL_W   = 8;
  localparam int unsigned STATE_W    = 4;
  localparam int unsigned ERR_W      = 2;
  localparam int unsigned MASK_W     = 16;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes; the last index has no register behind it.
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // What an input item asks for.
  typedef enum logic [MODE_W-1:0] {
    MODE_DECLARE = 2'd0,
    MODE_LOAD    = 2'd1,
    MODE_RUN     = 2'd2,
    MODE_END     = 2'd3
  } mode_e;

  // Error codes carried by every result.
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE    = 2'd0,
    ERR_SYMBOL  = 2'd1,
    ERR_MISSING = 2'd2,
    ERR_STATE   = 2'd3
  } err_e;

  // One transition table entry: a valid flag and the destination state.
  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] to_state;
  } entry_t;

endpackage
`default_nettype wire

// ----- hdl/tdfa_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel that carries one automaton item per transfer.
// ----------------------------------------------------------------------------
interface tdfa_in_if;
  logic                           valid;
  logic                           ready;
  logic [tdfa_pkg::MODE_W-1:0]    mode;
  logic [tdfa_pkg::SYMBOL_W-1:0]  symbol;
  logic [tdfa_pkg::STATE_W-1:0]   from_state;
  logic [tdfa_pkg::STATE_W-1:0]   to_state;

  modport source (output valid, output mode, output symbol, output from_state,
                  output to_state, input ready);
  modport sink   (input valid, input mode, input symbol, input from_state,
                  input to_state, output ready);
endinterface
`default_nettype wire

// ----- hdl/tdfa_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
interface tdfa_out_if;
  logic                        valid;
  logic                        ready;
  logic                        verdict_valid;
  logic                        accepted;
  logic [tdfa_pkg::ERR_W-1:0]  error_code;

  modport source (output valid, output verdict_valid, output accepted,
                  output error_code, input ready);
  modport sink   (input valid, input verdict_valid, input accepted,
                  input error_code, output ready);
endinterface
`default_nettype wire

// ----- hdl/tdfa_table_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Transition table RAM
// Simple dual-port synchronous RAM, one write and one read port, with a
// registered read. A read and a write to the same address in one cycle
// return the old contents.
// ----------------------------------------------------------------------------
module tdfa_table_ram #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 5
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- hdl/tdfa_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DFA engine
// Two-stage pipeline around the transition table and the alphabet RAM. The
// issue stage reads both at the forwarded next state and the new symbol; the
// resolve stage checks the item, updates the current state, error and
// alphabet, writes loads back to the table and fills the output register.
// Also runs the clear sweep of both RAMs after reset.
// ----------------------------------------------------------------------------
module tdfa_engine #(
  parameter int unsigned MAX_STATES  = 16,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [tdfa_pkg::STATE_W-1:0]   start_state_i,
  input  wire logic [tdfa_pkg::MASK_W-1:0]    final_mask_i,
  input  wire logic [tdfa_pkg::COUNT_W-1:0]   state_count_i,
  tdfa_in_if.sink                             in_i,
  tdfa_out_if.source                          out_o
);

  localparam int unsigned SYM_COUNT   = 1 << SYMBOL_BITS;
  localparam int unsigned STATE_IDX_W = $clog2(MAX_STATES);
  localparam int unsigned DEPTH       = MAX_STATES * SYM_COUNT;
  localparam int unsigned ADDR_W      = STATE_IDX_W + SYMBOL_BITS;
  localparam int unsigned ENTRY_W     = $bits(tdfa_pkg::entry_t);
  localparam int unsigned CMP_W       = 9;

  // A state is declared when below both the state count and the table size.
  function automatic logic is_declared(input logic [tdfa_pkg::STATE_W-1:0] s,
                                       input logic [tdfa_pkg::COUNT_W-1:0] cnt);
    is_declared = ({1'b0, s} < cnt) && (CMP_W'(s) < CMP_W'(MAX_STATES));
  endfunction

  // Clear sweep state.
  logic              clearing_q;
  logic [ADDR_W-1:0] clr_cnt_q;

  // Architectural state.
  logic [tdfa_pkg::STATE_W-1:0] cur_q, cur_d;
  tdfa_pkg::err_e               err_q, err_d;

  // Resolve stage registers.
  logic                          s1_valid_q;
  tdfa_pkg::mode_e               s1_mode_q;
  logic [SYMBOL_BITS-1:0]        s1_sym_q;
  logic [tdfa_pkg::STATE_W-1:0]  s1_from_q;
  logic [tdfa_pkg::STATE_W-1:0]  s1_to_q;
  logic                          byp_hit_q;
  tdfa_pkg::entry_t              byp_data_q;
  logic                          mk_byp_q;

  // Output register.
  logic            out_valid_q;
  logic            out_verdict_q;
  logic            out_acc_q;
  tdfa_pkg::err_e  out_err_q;

  // Table ports.
  logic              tbl_we;
  logic [ADDR_W-1:0] tbl_waddr;
  tdfa_pkg::entry_t  tbl_wdata;
  logic [ADDR_W-1:0] rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  tdfa_pkg::entry_t  entry;

  // Alphabet RAM ports.
  logic                   mk_we;
  logic [SYMBOL_BITS-1:0] mk_waddr;
  logic                   mk_wdata;
  logic [0:0]             mk_rd;

  // Resolve stage results.
  logic                          advance;
  logic                          s1_fire;
  logic                          in_fire;
  logic [SYMBOL_BITS-1:0]        in_sym;
  logic                          sym_ok;
  logic                          load_ok;
  logic [tdfa_pkg::STATE_W-1:0]  nxt_state;
  tdfa_pkg::err_e                nxt_err;
  logic                          res_verdict;
  logic                          res_acc;
  tdfa_pkg::err_e                res_err;

  // Handshake: the resolve stage drains whenever the output register frees.
  assign advance   = !out_valid_q || out_o.ready;
  assign s1_fire   = s1_valid_q && advance;
  assign in_i.ready = !clearing_q && (!s1_valid_q || advance);
  assign in_fire   = in_i.valid && in_i.ready;
  assign in_sym    = in_i.symbol[SYMBOL_BITS-1:0];

  // Read data, overridden when the previous item wrote the same entry.
  assign entry  = byp_hit_q ? byp_data_q : tdfa_pkg::entry_t'(rd_data);
  assign sym_ok = mk_byp_q || mk_rd[0];

  // Resolve stage: checks, next state and result of the item in flight.
  always_comb begin
    nxt_state   = cur_q;
    nxt_err     = err_q;
    res_verdict = 1'b0;
    res_acc     = 1'b0;
    res_err     = tdfa_pkg::ERR_NONE;
    load_ok     = 1'b0;
    unique case (s1_mode_q)
      tdfa_pkg::MODE_DECLARE: begin
        res_err = tdfa_pkg::ERR_NONE;
      end
      tdfa_pkg::MODE_LOAD: begin
        if (!is_declared(s1_from_q, state_count_i)) begin
          res_err = tdfa_pkg::ERR_STATE;
        end else if (!sym_ok) begin
          res_err = tdfa_pkg::ERR_SYMBOL;
        end else if (!is_declared(s1_to_q, state_count_i)) begin
          res_err = tdfa_pkg::ERR_STATE;
        end else begin
          load_ok = 1'b1;
        end
      end
      tdfa_pkg::MODE_RUN: begin
        if (err_q == tdfa_pkg::ERR_NONE) begin
          if (!is_declared(cur_q, state_count_i)) begin
            nxt_err = tdfa_pkg::ERR_STATE;
          end else if (!sym_ok) begin
            nxt_err = tdfa_pkg::ERR_SYMBOL;
          end else if (!entry.valid) begin
            nxt_err = tdfa_pkg::ERR_MISSING;
          end else begin
            nxt_state = entry.to_state;
          end
        end
        res_err = nxt_err;
      end
      tdfa_pkg::MODE_END: begin
        res_err = err_q;
        if (err_q == tdfa_pkg::ERR_NONE && !is_declared(cur_q, state_count_i)) begin
          res_err = tdfa_pkg::ERR_STATE;
        end
        res_verdict = 1'b1;
        res_acc     = (res_err == tdfa_pkg::ERR_NONE) && final_mask_i[cur_q];
        nxt_state   = start_state_i;
        nxt_err     = tdfa_pkg::ERR_NONE;
      end
      default: begin
        res_err = tdfa_pkg::ERR_NONE;
      end
    endcase
  end

  // Next state is forwarded straight into the issue-stage read address.
  assign cur_d   = s1_fire ? nxt_state : cur_q;
  assign err_d   = s1_fire ? nxt_err : err_q;
  assign rd_addr = {STATE_IDX_W'(cur_d), in_sym};

  // Table write: clear sweep after reset, otherwise accepted loads.
  always_comb begin
    if (clearing_q) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr_cnt_q;
      tbl_wdata = '0;
    end else begin
      tbl_we             = s1_fire && (s1_mode_q == tdfa_pkg::MODE_LOAD) && load_ok;
      tbl_waddr          = {STATE_IDX_W'(s1_from_q), s1_sym_q};
      tbl_wdata.valid    = 1'b1;
      tbl_wdata.to_state = s1_to_q;
    end
  end

  // Alphabet write: cleared by the same sweep, otherwise marked by declares.
  always_comb begin
    if (clearing_q) begin
      mk_we    = 1'b1;
      mk_waddr = clr_cnt_q[SYMBOL_BITS-1:0];
      mk_wdata = 1'b0;
    end else begin
      mk_we    = s1_fire && (s1_mode_q == tdfa_pkg::MODE_DECLARE);
      mk_waddr = s1_sym_q;
      mk_wdata = 1'b1;
    end
  end

  tdfa_table_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (ENTRY_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (in_fire),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  tdfa_table_ram #(
    .DEPTH  (SYM_COUNT),
    .ADDR_W (SYMBOL_BITS),
    .DATA_W (1)
  ) u_marks (
    .clk_i   (clk_i),
    .we_i    (mk_we),
    .waddr_i (mk_waddr),
    .wdata_i (mk_wdata),
    .re_i    (in_fire),
    .raddr_i (in_sym),
    .rdata_o (mk_rd)
  );

  // Clear sweep over every table entry, once after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == ADDR_W'(DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Current state and sticky error.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      err_q   <= tdfa_pkg::ERR_NONE;
    end else begin
      cur_q <= cur_d;
      err_q <= err_d;
    end
  end

  // Resolve stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Resolve stage payload and same-entry bypasses, captured on each transfer.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mode_q  <= tdfa_pkg::mode_e'(in_i.mode);
      s1_sym_q   <= in_sym;
      s1_from_q  <= in_i.from_state;
      s1_to_q    <= in_i.to_state;
      byp_hit_q  <= tbl_we && (tbl_waddr == rd_addr);
      byp_data_q <= tbl_wdata;
      mk_byp_q   <= mk_we && (mk_waddr == in_sym);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_verdict_q <= res_verdict;
      out_acc_q     <= res_acc;
      out_err_q     <= res_err;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.verdict_valid = out_verdict_q;
  assign out_o.accepted      = out_acc_q;
  assign out_o.error_code    = out_err_q;

  // A stalled item keeps its stage until the output register frees.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> (s1_valid_q && $stable(s1_sym_q) && $stable(cur_q)))
    else $error("resolve stage changed while the output was stalled");

  // A pending error freezes the current state for further symbols.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_mode_q == tdfa_pkg::MODE_RUN && err_q != tdfa_pkg::ERR_NONE)
      |=> $stable(cur_q))
    else $error("state moved while an error was pending");

  // End of string restarts at the start state with no error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_mode_q == tdfa_pkg::MODE_END)
      |=> (err_q == tdfa_pkg::ERR_NONE && cur_q == $past(start_state_i)))
    else $error("end of string did not restart the automaton");

  // Outside the clear sweep, the table is written by accepted loads only.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tbl_we && !clearing_q) |-> (s1_fire && s1_mode_q == tdfa_pkg::MODE_LOAD))
    else $error("table written by something other than a load");

  // The sweep ends only after the last entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing_q) |-> ($past(clr_cnt_q) == ADDR_W'(DEPTH - 1)))
    else $error("clear sweep ended early");

endmodule
`default_nettype wire

// ----- hdl/table_driven_dfa_acceptor.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Table-driven DFA acceptor
// Programmable deterministic finite automaton with an alphabet, a transition
// table in RAM and per-string acceptance verdicts.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on in_i (valid/ready). Mode 0 declares a symbol, mode 1
//   loads a transition, mode 2 runs a symbol, mode 3 ends the string and
//   returns a verdict. Every item gives exactly one result on out_o.
//   Throughput is one item per cycle while out_o is not stalled, including
//   runs of mode 2 symbols: the table read for one symbol and the
//   next-state selection for the previous one close in the same cycle,
//   with the new state forwarded into the read address. The result is
//   loaded into the output register when the item leaves the resolve
//   stage and is offered on out_o from there.
//   After reset the table and the alphabet are swept clear, one entry a
//   cycle, over all MAX_STATES * 2**SYMBOL_BITS table addresses (4096 with
//   the defaults); in_i.ready stays low during the sweep. Configuration
//   writes are taken at any time.
//   When the receiver stalls, one result waits in the output register and
//   one item in the resolve stage; then in_i.ready drops until out_o.ready.
//   Configuration registers (cfg_idx_i): 0 start state, 1 final mask,
//   2 state count; index 3 is ignored.
// ----------------------------------------------------------------------------
module table_driven_dfa_acceptor #(
  parameter int unsigned MAX_STATES  = 16,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [tdfa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tdfa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  tdfa_in_if.sink                               in_i,
  tdfa_out_if.source                            out_o
);

  logic [tdfa_pkg::STATE_W-1:0] start_q;
  logic [tdfa_pkg::MASK_W-1:0]  final_q;
  logic [tdfa_pkg::COUNT_W-1:0] count_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      final_q <= '0;
      count_q <= tdfa_pkg::COUNT_W'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tdfa_pkg::CFG_START: start_q <= cfg_data_i[tdfa_pkg::STATE_W-1:0];
        tdfa_pkg::CFG_FINAL: final_q <= cfg_data_i[tdfa_pkg::MASK_W-1:0];
        tdfa_pkg::CFG_COUNT: count_q <= cfg_data_i[tdfa_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tdfa_engine #(
    .MAX_STATES  (MAX_STATES),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_state_i (start_q),
    .final_mask_i  (final_q),
    .state_count_i (count_q),
    .in_i          (in_i),
    .out_o         (out_o)
  );

endmodule
`default_nettype wire

// ----- verif/table_driven_dfa_acceptor_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table-driven DFA acceptor testbench
// Sends declare, load, run and end items with random idling, back-pressure
// and one long receiver hold. A behavioral automaton predicts every result,
// and each result transfer is checked in order, field by field.
// ----------------------------------------------------------------------------
module table_driven_dfa_acceptor_tb;

  localparam int unsigned NUM_STATES   = 16;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_ITEMS  = 215;
  localparam int unsigned RANDOM_PHASES = 8;

  typedef struct packed {
    tdfa_pkg::mode_e                mode;
    logic [tdfa_pkg::SYMBOL_W-1:0]  symbol;
    logic [tdfa_pkg::STATE_W-1:0]   from_state;
    logic [tdfa_pkg::STATE_W-1:0]   to_state;
  } dfa_item_t;

  typedef struct packed {
    logic verdict_valid;
    logic accepted;
    tdfa_pkg::err_e error_code;
  } dfa_result_t;

  logic                            clk_i  = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we;
  logic [tdfa_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [tdfa_pkg::CFG_DATA_W-1:0] cfg_data;

  tdfa_in_if  in_if ();
  tdfa_out_if out_if ();

  // Shadow of the configuration registers.
  logic [tdfa_pkg::STATE_W-1:0] start_cfg = '0;
  logic [tdfa_pkg::MASK_W-1:0]  final_cfg = '0;
  logic [tdfa_pkg::COUNT_W-1:0] count_cfg = 5'd16;

  // Shadow of the automaton state.
  logic [tdfa_pkg::STATE_W-1:0] cur_state  = '0;
  tdfa_pkg::err_e               sticky_err = tdfa_pkg::ERR_NONE;
  tdfa_pkg::entry_t             trans_table [NUM_STATES * 256] = '{default: '0};
  logic [255:0]                 alphabet = '0;

  dfa_item_t   pending_q [$];
  dfa_result_t verdict_q [$];

  int unsigned items_queued   = 0;
  int unsigned items_taken    = 0;
  int unsigned results_seen   = 0;
  int unsigned verdicts_seen  = 0;
  int unsigned accepts_seen   = 0;
  int unsigned fail_count     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_asked     = 0;
  int unsigned hold_served    = 0;
  int unsigned hold_left      = 0;
  logic        in_took        = 1'b0;

  table_driven_dfa_acceptor DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // State count above the state limit acts as the limit.
  function automatic int unsigned live_states();
    return (int'(count_cfg) > NUM_STATES) ? NUM_STATES : int'(count_cfg);
  endfunction

  // Advances the shadow automaton by one item and returns its result.
  function automatic dfa_result_t step_automaton(dfa_item_t it);
    dfa_result_t res;
    logic [11:0] slot;
    int unsigned live;
    res  = '{1'b0, 1'b0, tdfa_pkg::ERR_NONE};
    live = live_states();
    case (it.mode)
      tdfa_pkg::MODE_DECLARE: begin
        alphabet[it.symbol] = 1'b1;
      end
      tdfa_pkg::MODE_LOAD: begin
        if (it.from_state >= live) res.error_code = tdfa_pkg::ERR_STATE;
        else if (!alphabet[it.symbol]) res.error_code = tdfa_pkg::ERR_SYMBOL;
        else if (it.to_state >= live) res.error_code = tdfa_pkg::ERR_STATE;
        else trans_table[{it.from_state, it.symbol}] = '{1'b1, it.to_state};
      end
      tdfa_pkg::MODE_RUN: begin
        // Once a string has an error, its remaining symbols are ignored.
        if (sticky_err == tdfa_pkg::ERR_NONE) begin
          slot = {cur_state, it.symbol};
          if (cur_state >= live) sticky_err = tdfa_pkg::ERR_STATE;
          else if (!alphabet[it.symbol]) sticky_err = tdfa_pkg::ERR_SYMBOL;
          else if (!trans_table[slot].valid) sticky_err = tdfa_pkg::ERR_MISSING;
          else cur_state = trans_table[slot].to_state;
        end
        res.error_code = sticky_err;
      end
      default: begin
        if (sticky_err == tdfa_pkg::ERR_NONE && cur_state >= live) begin
          sticky_err = tdfa_pkg::ERR_STATE;
        end
        res.verdict_valid = 1'b1;
        res.error_code    = sticky_err;
        res.accepted      = (sticky_err == tdfa_pkg::ERR_NONE) && final_cfg[cur_state];
        cur_state  = start_cfg;
        sticky_err = tdfa_pkg::ERR_NONE;
      end
    endcase
    return res;
  endfunction

  function automatic void check_field(string name, logic [1:0] want, logic [1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void queue_item(tdfa_pkg::mode_e m,
                                     logic [tdfa_pkg::SYMBOL_W-1:0] sym,
                                     logic [tdfa_pkg::STATE_W-1:0] from_s,
                                     logic [tdfa_pkg::STATE_W-1:0] to_s);
    pending_q.push_back('{m, sym, from_s, to_s});
    items_queued++;
  endfunction

  // Driver: presents the next pending item once the current one transferred.
  always @(negedge clk_i) begin
    dfa_item_t nxt;
    if (!in_if.valid || in_took) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_q.pop_front();
        in_if.valid      <= 1'b1;
        in_if.mode       <= nxt.mode;
        in_if.symbol     <= nxt.symbol;
        in_if.from_state <= nxt.from_state;
        in_if.to_state   <= nxt.to_state;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold whenever one is requested.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      out_if.ready <= 1'b0;
      hold_served  <= hold_served + 1;
      hold_left    <= HOLD_CYCLES;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: checks each result transfer, then predicts for each input transfer.
  always @(posedge clk_i) begin
    dfa_result_t got;
    dfa_result_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.verdict_valid, out_if.accepted,
                tdfa_pkg::err_e'(out_if.error_code)};
        results_seen++;
        if (verdict_q.size() == 0) begin
          $error("result transfer with no result expected");
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (want.verdict_valid) verdicts_seen++;
          if (want.accepted) accepts_seen++;
          check_field("verdict_valid", want.verdict_valid, got.verdict_valid);
          check_field("accepted", want.accepted, got.accepted);
          check_field("error_code", want.error_code, got.error_code);
        end
      end
      if (in_if.valid && in_if.ready) begin
        verdict_q.push_back(step_automaton('{tdfa_pkg::mode_e'(in_if.mode), in_if.symbol,
                                             in_if.from_state, in_if.to_state}));
        items_taken++;
      end
    end
    in_took <= rst_ni && in_if.valid && in_if.ready;
  end

  // Register write while the block is idle; the shadow follows it.
  task automatic write_cfg(logic [tdfa_pkg::CFG_IDX_W-1:0] idx,
                           logic [tdfa_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      tdfa_pkg::CFG_START: start_cfg = data[tdfa_pkg::STATE_W-1:0];
      tdfa_pkg::CFG_FINAL: final_cfg = data;
      tdfa_pkg::CFG_COUNT: count_cfg = data[tdfa_pkg::COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // Waits until every queued item has transferred and its result has arrived.
  task automatic wait_idle();
    while (items_taken != items_queued || verdict_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [tdfa_pkg::STATE_W-1:0] pick_state(int unsigned live);
    if ($urandom_range(9) == 0) return tdfa_pkg::STATE_W'($urandom_range(NUM_STATES - 1));
    return tdfa_pkg::STATE_W'($urandom_range(live - 1));
  endfunction

  function automatic logic [tdfa_pkg::SYMBOL_W-1:0] pick_symbol(
      logic [tdfa_pkg::SYMBOL_W-1:0] syms [$]);
    if ($urandom_range(99) < 7) return tdfa_pkg::SYMBOL_W'($urandom);
    return syms[$urandom_range(syms.size() - 1)];
  endfunction

  // One random phase: a few new symbols, a dense table over the live states,
  // then strings that mostly follow the table, with some noise in between.
  task automatic build_phase(int unsigned n_items);
    logic [tdfa_pkg::SYMBOL_W-1:0] syms [$];
    logic [tdfa_pkg::SYMBOL_W-1:0] s;
    int unsigned live;
    int unsigned target;
    int unsigned st;
    target = items_queued + n_items;
    live   = live_states();
    repeat ($urandom_range(2, 5)) begin
      s = tdfa_pkg::SYMBOL_W'($urandom);
      syms.push_back(s);
      queue_item(tdfa_pkg::MODE_DECLARE, s, tdfa_pkg::STATE_W'($urandom),
                 tdfa_pkg::STATE_W'($urandom));
    end
    for (st = 0; st < live; st++) begin
      foreach (syms[j]) begin
        if ($urandom_range(9) < 8) begin
          queue_item(tdfa_pkg::MODE_LOAD, syms[j], tdfa_pkg::STATE_W'(st),
                     pick_state(live));
        end
      end
    end
    while (items_queued < target) begin
      if ($urandom_range(19) == 0) begin
        if ($urandom_range(1)) begin
          queue_item(tdfa_pkg::MODE_DECLARE, tdfa_pkg::SYMBOL_W'($urandom),
                     tdfa_pkg::STATE_W'($urandom), tdfa_pkg::STATE_W'($urandom));
        end else begin
          queue_item(tdfa_pkg::MODE_LOAD, pick_symbol(syms),
                     tdfa_pkg::STATE_W'($urandom), tdfa_pkg::STATE_W'($urandom));
        end
      end
      repeat ($urandom_range(0, 10)) begin
        queue_item(tdfa_pkg::MODE_RUN, pick_symbol(syms),
                   tdfa_pkg::STATE_W'($urandom), tdfa_pkg::STATE_W'($urandom));
      end
      queue_item(tdfa_pkg::MODE_END, tdfa_pkg::SYMBOL_W'($urandom),
                 tdfa_pkg::STATE_W'($urandom), tdfa_pkg::STATE_W'($urandom));
    end
    // Sometimes leave a string open across the next register writes.
    if ($urandom_range(1)) begin
      repeat ($urandom_range(1, 3)) begin
        queue_item(tdfa_pkg::MODE_RUN, pick_symbol(syms),
                   tdfa_pkg::STATE_W'($urandom), tdfa_pkg::STATE_W'($urandom));
      end
    end
  endtask

  // Stimulus and end of run.
  initial begin
    int unsigned phase_counts [RANDOM_PHASES];
    int unsigned phase;
    int unsigned live;
    phase_counts = '{16, 1, 31, 5, 16, 2, 12, 16};
    in_if.valid      = 1'b0;
    in_if.mode       = tdfa_pkg::MODE_DECLARE;
    in_if.symbol     = '0;
    in_if.from_state = '0;
    in_if.to_state   = '0;
    out_if.ready     = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = tdfa_pkg::CFG_START;
    cfg_data = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Four declared states with state 3 accepting; upper data bits are dropped.
    write_cfg(tdfa_pkg::CFG_COUNT, 16'd4);
    write_cfg(tdfa_pkg::CFG_FINAL, 16'h0008);
    write_cfg(tdfa_pkg::CFG_START, 16'hFFF0);
    write_cfg(tdfa_pkg::CFG_UNUSED, 16'hFFFF);
    @(posedge clk_i);
    queue_item(tdfa_pkg::MODE_END, 8'h00, 4'd0, 4'd0);      // empty string, non-final
    queue_item(tdfa_pkg::MODE_RUN, 8'h41, 4'd0, 4'd0);      // symbol outside the alphabet
    queue_item(tdfa_pkg::MODE_RUN, 8'hFF, 4'd0, 4'd0);      // ignored after the error
    queue_item(tdfa_pkg::MODE_END, 8'h00, 4'd0, 4'd0);
    queue_item(tdfa_pkg::MODE_DECLARE, 8'h00, 4'd0, 4'd0);
    queue_item(tdfa_pkg::MODE_DECLARE, 8'hFF, 4'd0, 4'd0);
    queue_item(tdfa_pkg::MODE_DECLARE, 8'h41, 4'd0, 4'd0);
    queue_item(tdfa_pkg::MODE_DECLARE, 8'h41, 4'd0, 4'd0);  // declaring twice is harmless
    queue_item(tdfa_pkg::MODE_LOAD, 8'h41, 4'd5, 4'd1);     // undeclared source state
    queue_item(tdfa_pkg::MODE_LOAD, 8'h42, 4'd0, 4'd1);     // undeclared symbol
    queue_item(tdfa_pkg::MODE_LOAD, 8'h41, 4'd0, 4'd15);    // undeclared destination
    queue_item(tdfa_pkg::MODE_LOAD, 8'h41, 4'd0, 4'd2);
    queue_item(tdfa_pkg::MODE_LOAD, 8'h41, 4'd0, 4'd1);     // overwrites the entry above
    queue_item(tdfa_pkg::MODE_LOAD, 8'hFF, 4'd1, 4'd3);
    queue_item(tdfa_pkg::MODE_LOAD, 8'h00, 4'd3, 4'd3);
    queue_item(tdfa_pkg::MODE_RUN, 8'h41, 4'd0, 4'd0);
    queue_item(tdfa_pkg::MODE_RUN, 8'hFF, 4'd0, 4'd0);
    queue_item(tdfa_pkg::MODE_RUN, 8'h00, 4'd0, 4'd0);
    queue_item(tdfa_pkg::MODE_END, 8'h00, 4'd0, 4'd0);      // ends in the final state
    queue_item(tdfa_pkg::MODE_RUN, 8'h00, 4'd0, 4'd0);      // transition never loaded
    queue_item(tdfa_pkg::MODE_END, 8'h00, 4'd0, 4'd0);
    queue_item(tdfa_pkg::MODE_RUN, 8'h41, 4'd0, 4'd0);
    queue_item(tdfa_pkg::MODE_RUN, 8'hFF, 4'd0, 4'd0);      // string left open in state 3
    wait_idle();

    // Shrinking the state count strands the open string in an undeclared state.
    write_cfg(tdfa_pkg::CFG_COUNT, 16'd2);
    @(posedge clk_i);
    queue_item(tdfa_pkg::MODE_END, 8'h00, 4'd0, 4'd0);
    wait_idle();

    // No declared state at all.
    write_cfg(tdfa_pkg::CFG_COUNT, 16'd0);
    @(posedge clk_i);
    queue_item(tdfa_pkg::MODE_LOAD, 8'h41, 4'd0, 4'd0);
    queue_item(tdfa_pkg::MODE_RUN, 8'h41, 4'd0, 4'd0);
    queue_item(tdfa_pkg::MODE_END, 8'h00, 4'd0, 4'd0);
    wait_idle();

    // A count above the limit declares every state; start in the top state.
    write_cfg(tdfa_pkg::CFG_COUNT, 16'd31);
    write_cfg(tdfa_pkg::CFG_FINAL, 16'h8000);
    write_cfg(tdfa_pkg::CFG_START, 16'd15);
    @(posedge clk_i);
    queue_item(tdfa_pkg::MODE_LOAD, 8'hFF, 4'd15, 4'd15);
    queue_item(tdfa_pkg::MODE_END, 8'h00, 4'd0, 4'd0);
    queue_item(tdfa_pkg::MODE_RUN, 8'hFF, 4'd0, 4'd0);
    queue_item(tdfa_pkg::MODE_END, 8'h00, 4'd0, 4'd0);
    wait_idle();

    // Random phases, each with its own registers and idling pattern.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_cfg(tdfa_pkg::CFG_COUNT,
                tdfa_pkg::CFG_DATA_W'(phase_counts[phase] | ($urandom & 32'hFFE0)));
      live = live_states();
      if ($urandom_range(7) == 0) begin
        write_cfg(tdfa_pkg::CFG_START, 16'd15);
      end else begin
        write_cfg(tdfa_pkg::CFG_START, tdfa_pkg::CFG_DATA_W'($urandom_range(live - 1)));
      end
      if (phase == 1) write_cfg(tdfa_pkg::CFG_FINAL, 16'hFFFF);
      else if (phase == 2) write_cfg(tdfa_pkg::CFG_FINAL, 16'h0000);
      else write_cfg(tdfa_pkg::CFG_FINAL, tdfa_pkg::CFG_DATA_W'($urandom));
      @(posedge clk_i);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      // The sender keeps offering items while the receiver is held off.
      if (phase == 4) hold_asked++;
      build_phase(PHASE_ITEMS);
      wait_idle();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d items and %0d results; %0d strings ended, %0d accepted.",
             items_taken, results_seen, verdicts_seen, accepts_seen);
    $display("Register settings spanned zero to over-limit state counts under idling.");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $error("timeout: %0d of %0d items transferred, %0d results pending",
           items_taken, items_queued, verdict_q.size());
    $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/tdfa_pkg.sv
hdl/tdfa_in_if.sv
hdl/tdfa_out_if.sv
hdl/tdfa_table_ram.sv
hdl/tdfa_engine.sv
hdl/table_driven_dfa_acceptor.sv
verif/table_driven_dfa_acceptor_tb.sv
